// ----- rtl/sgnt_pkg.sv -----
// Shared types and codes for the sequence gap tracker.
package sgnt_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = 6;

  // Request codes
  localparam logic [1:0] REQ_PACKET  = 2'd0;
  localparam logic [1:0] REQ_COLLECT = 2'd1;
  localparam logic [1:0] REQ_RESET   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_MIN_REORDER = 2'd0;
  localparam logic [1:0] CFG_MAX_REORDER = 2'd1;
  localparam logic [1:0] CFG_WINDOW      = 2'd2;
  localparam logic [1:0] CFG_MAX_REQ     = 2'd3;

  // Command broadcast to every cell
  typedef struct packed {
    logic              load;
    logic              shift;
    logic              do_late;
    logic              do_clear;
    logic              do_fwd;
    logic              do_collect;
    logic [SLOT_W-1:0] late_slot;
    logic [31:0]       cur_high;
    logic [SLOT_W-1:0] high_slot;
    logic [6:0]        fwd_d;
    logic [6:0]        win;
    logic [SLOT_W-1:0] ins_slot;
    logic [6:0]        tracked;
    logic [15:0]       tol;
    logic [7:0]        max_req;
  } sgnt_cmd_t;

  // Per-cell event flags, passed round the ring for counting and emission
  typedef struct packed {
    logic gu;
    logic rq;
    logic rec;
    logic vl;
  } sgnt_flags_t;

endpackage

// ----- rtl/sgnt_cell.sv -----
// One gap slot: entry state, local update logic and one ring stage of flags.
module sgnt_cell import sgnt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] slot_id,
  input  sgnt_cmd_t         cmd,
  input  sgnt_flags_t       ring_in,
  output sgnt_flags_t       ring_out
);

  logic        valid, valid_next;
  logic [7:0]  req_cnt, req_cnt_next, req_inc;
  logic [31:0] last_req_at, last_req_at_next, since_req;
  sgnt_flags_t flags, flags_next;
  logic [SLOT_W-1:0] age, ins_off;
  logic [7:0]  age_sum;

  assign age       = cmd.high_slot - slot_id;
  assign ins_off   = cmd.ins_slot - slot_id;
  assign age_sum   = {2'b00, age} + {1'b0, cmd.fwd_d};
  assign since_req = cmd.cur_high - last_req_at;
  assign req_inc   = req_cnt + 8'd1;

  // Entry update for the current command
  always_comb begin
    valid_next       = valid;
    req_cnt_next     = req_cnt;
    last_req_at_next = last_req_at;
    flags_next       = '0;
    if (cmd.do_late && slot_id == cmd.late_slot && valid) begin
      valid_next     = 1'b0;
      flags_next.rec = (req_cnt != 8'd0);
    end
    if (cmd.do_clear) begin
      valid_next = 1'b0;
    end
    if (cmd.do_fwd) begin
      // age out first, then mark the skipped numbers
      if (valid && age_sum >= {1'b0, cmd.win}) begin
        flags_next.gu = 1'b1;
        valid_next    = 1'b0;
      end
      if (ins_off != '0 && {1'b0, ins_off} <= cmd.tracked) begin
        valid_next       = 1'b1;
        req_cnt_next     = 8'd0;
        last_req_at_next = 32'd0;
      end
    end
    if (cmd.do_collect && valid && age != '0) begin
      if (req_cnt >= cmd.max_req) begin
        flags_next.gu = 1'b1;
        valid_next    = 1'b0;
      end else if ({10'd0, age} >= cmd.tol &&
                   !(req_cnt != 8'd0 && since_req < {16'd0, cmd.tol})) begin
        flags_next.rq    = 1'b1;
        req_cnt_next     = req_inc;
        last_req_at_next = cmd.cur_high;
        if (req_inc >= cmd.max_req) begin
          flags_next.gu = 1'b1;
          valid_next    = 1'b0;
        end
      end
    end
    flags_next.vl = valid_next;
  end

  // Control state: valid bit and ring flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      flags <= '0;
    end else if (cmd.load) begin
      valid <= valid_next;
      flags <= flags_next;
    end else if (cmd.shift) begin
      flags <= ring_in;
    end
  end

  // Payload: request count and time of last request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cnt     <= req_cnt_next;
      last_req_at <= last_req_at_next;
    end
  end

  assign ring_out = flags;

endmodule

// ----- rtl/sgnt_chain.sv -----
// Ring of gap cells; flags rotate towards cell 0, which is the read tap.
module sgnt_chain import sgnt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sgnt_cmd_t   cmd,
  output sgnt_flags_t head
);

  sgnt_flags_t ring [SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    sgnt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot_id  (SLOT_W'(i)),
      .cmd      (cmd),
      .ring_in  (ring[(i + 1) % SLOTS]),
      .ring_out (ring[i])
    );
  end

  assign head = ring[0];

endmodule

// ----- rtl/seq_gap_nack_tracker_top.sv -----
// Sequence gap tracker top level: control, counters and result channel.
//
// Each request passes from acceptance to its first result through a decode
// state, a load state in which all 64 gap cells update in parallel, and a
// count state while the cells' event flags rotate past the tap at cell 0 to
// be counted. A collect then rotates the ring further, first to line up on the
// oldest slot and then 63 steps to walk oldest to newest, at most one target
// per step, waiting whenever the consumer stalls. Every result of a request carries the
// counters as they stand after the whole request. One request is handled at
// a time.
module seq_gap_nack_tracker_top import sgnt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] seq,
  input  logic [15:0] frag_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic        last,
  output logic [31:0] nack_seq,
  output logic [5:0]  pending_count,
  output logic [31:0] packets_seen_total,
  output logic [31:0] recovered_total,
  output logic [31:0] discontinuity_total,
  output logic [31:0] given_up_total,
  output logic [31:0] lost_total,
  output logic [31:0] requests_total
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_COUNT = 3'd3;
  localparam logic [2:0] ST_SEEK  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_HOLD  = 3'd6;

  logic [2:0]  state;
  logic [1:0]  item_type;
  logic [31:0] item_seq;
  logic [15:0] item_frag;
  logic [15:0] min_reorder, max_reorder;
  logic [6:0]  window;
  logic [7:0]  max_req;
  logic [31:0] high;
  logic        base_set;
  logic [15:0] tol;
  logic [6:0]  pending;
  logic [31:0] packets_cnt, recovered_cnt, disc_cnt, given_up_cnt, lost_cnt, req_cnt;
  sgnt_cmd_t   cmd_q, cmd, cmd_prep;
  sgnt_flags_t head;
  logic [SLOT_W-1:0] pos, step, target, emit_age;
  logic [1:0]  kind_q;
  logic        last_q;
  logic [31:0] nack_q;

  // Decode of the latched request
  logic [31:0] d, back_age;
  logic        is_back, late_ok, jump;
  logic [6:0]  win_eff, d_small, tracked, extra;
  logic [15:0] lo, hi, tol_new;

  assign d        = item_seq - high;
  assign back_age = high - item_seq;
  assign is_back  = (d == 32'd0) || d[31];
  assign late_ok  = (back_age != 32'd0) && (back_age[31:SLOT_W] == '0);
  assign win_eff  = (window > 7'd64) ? 7'd64 : window;
  assign jump     = d >= {25'd0, win_eff};
  assign d_small  = d[6:0];
  assign tracked  = ((d_small - 7'd1) < (win_eff - 7'd1)) ? (d_small - 7'd1)
                                                          : (win_eff - 7'd1);
  assign extra    = (d_small - 7'd1) - tracked;
  assign lo       = (min_reorder < max_reorder) ? min_reorder : max_reorder;
  assign hi       = (min_reorder < max_reorder) ? max_reorder : min_reorder;
  assign tol_new  = (item_frag < lo) ? lo : ((item_frag > hi) ? hi : item_frag);

  assign target   = cmd_q.high_slot + SLOT_W'(1);
  assign emit_age = cmd_q.high_slot - pos;

  // Cell command for the latched request
  always_comb begin
    cmd_prep           = '0;
    cmd_prep.late_slot = item_seq[SLOT_W-1:0];
    cmd_prep.cur_high  = high;
    cmd_prep.high_slot = high[SLOT_W-1:0];
    cmd_prep.fwd_d     = d_small;
    cmd_prep.win       = win_eff;
    cmd_prep.ins_slot  = item_seq[SLOT_W-1:0];
    cmd_prep.tracked   = tracked;
    cmd_prep.tol       = tol;
    cmd_prep.max_req   = max_req;
    case (item_type)
      REQ_PACKET: begin
        if (base_set) begin
          if (is_back) begin
            cmd_prep.do_late = late_ok;
          end else if (jump) begin
            cmd_prep.do_clear = 1'b1;
          end else begin
            cmd_prep.do_fwd = 1'b1;
          end
        end
      end
      REQ_COLLECT: cmd_prep.do_collect = base_set;
      REQ_RESET:   cmd_prep.do_clear   = 1'b1;
      default: ;
    endcase
  end

  // Cell command: registered fields plus load and shift strobes
  always_comb begin
    cmd       = cmd_q;
    cmd.load  = (state == ST_EXEC);
    cmd.shift = (state == ST_COUNT) ||
                (state == ST_SEEK && pos != target) ||
                (state == ST_EMIT && !head.rq) ||
                (state == ST_HOLD && out_ready && !last_q);
  end

  sgnt_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .head (head)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_reorder <= 16'd2;
      max_reorder <= 16'd32;
      window      <= 7'd64;
      max_req     <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MIN_REORDER: min_reorder <= cfg_wdata;
        CFG_MAX_REORDER: max_reorder <= cfg_wdata;
        CFG_WINDOW:      window      <= cfg_wdata[6:0];
        CFG_MAX_REQ:     max_req     <= cfg_wdata[7:0];
        default:         ;
      endcase
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_type <= req_type;
      item_seq  <= seq;
      item_frag <= frag_count;
    end
  end

  // Sequencer, tracker state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      high          <= 32'd0;
      base_set      <= 1'b0;
      tol           <= 16'd0;
      pending       <= 7'd0;
      packets_cnt   <= 32'd0;
      recovered_cnt <= 32'd0;
      disc_cnt      <= 32'd0;
      given_up_cnt  <= 32'd0;
      lost_cnt      <= 32'd0;
      req_cnt       <= 32'd0;
      cmd_q         <= '0;
      pos           <= '0;
      step          <= '0;
      kind_q        <= KIND_STATUS;
      last_q        <= 1'b0;
      nack_q        <= 32'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_PREP;
        end
        ST_PREP: begin
          cmd_q   <= cmd_prep;
          pending <= 7'd0;
          pos     <= '0;
          case (item_type)
            REQ_PACKET: begin
              packets_cnt <= packets_cnt + 32'd1;
              tol         <= tol_new;
              if (!base_set) begin
                high     <= item_seq;
                base_set <= 1'b1;
              end else if (!is_back && jump) begin
                high     <= item_seq;
                disc_cnt <= disc_cnt + 32'd1;
              end else if (!is_back) begin
                high         <= item_seq;
                given_up_cnt <= given_up_cnt + {25'd0, extra};
                lost_cnt     <= lost_cnt + {25'd0, extra};
              end
            end
            REQ_RESET: begin
              high     <= 32'd0;
              tol      <= 16'd0;
              base_set <= 1'b0;
            end
            default: ;
          endcase
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_COUNT;
        end
        ST_COUNT: begin
          // tally the flags of the slot now at the tap
          given_up_cnt  <= given_up_cnt + {31'd0, head.gu};
          lost_cnt      <= lost_cnt + {31'd0, head.gu};
          req_cnt       <= req_cnt + {31'd0, head.rq};
          recovered_cnt <= recovered_cnt + {31'd0, head.rec};
          pending       <= pending + {6'd0, head.vl};
          pos           <= pos + SLOT_W'(1);
          if (pos == '1) begin
            if (item_type == REQ_COLLECT) begin
              state <= ST_SEEK;
            end else begin
              kind_q <= KIND_STATUS;
              last_q <= 1'b1;
              nack_q <= 32'd0;
              state  <= ST_HOLD;
            end
          end
        end
        ST_SEEK: begin
          // line up the oldest slot at the tap
          if (pos == target) begin
            step  <= '0;
            state <= ST_EMIT;
          end else begin
            pos <= pos + SLOT_W'(1);
          end
        end
        ST_EMIT: begin
          if (head.rq) begin
            kind_q <= KIND_TARGET;
            last_q <= 1'b0;
            nack_q <= cmd_q.cur_high - {26'd0, emit_age};
            state  <= ST_HOLD;
          end else begin
            pos  <= pos + SLOT_W'(1);
            step <= step + SLOT_W'(1);
            if (step == SLOT_W'(SLOTS - 2)) begin
              kind_q <= KIND_END;
              last_q <= 1'b1;
              nack_q <= 32'd0;
              state  <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_ready) begin
            if (last_q) begin
              state <= ST_IDLE;
            end else begin
              pos  <= pos + SLOT_W'(1);
              step <= step + SLOT_W'(1);
              if (step == SLOT_W'(SLOTS - 2)) begin
                kind_q <= KIND_END;
                last_q <= 1'b1;
                nack_q <= 32'd0;
              end else begin
                state <= ST_EMIT;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready            = (state == ST_IDLE);
  assign out_valid           = (state == ST_HOLD);
  assign result_kind         = kind_q;
  assign last                = last_q;
  assign nack_seq            = nack_q;
  assign pending_count       = pending[5:0];
  assign packets_seen_total  = packets_cnt;
  assign recovered_total     = recovered_cnt;
  assign discontinuity_total = disc_cnt;
  assign given_up_total      = given_up_cnt;
  assign lost_total          = lost_cnt;
  assign requests_total      = req_cnt;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("request taken while a result waits");
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_PREP) else $error("accepted request not decoded");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready) else $error("no return to idle after last");
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> pending < 7'd64) else $error("pending gap count out of range");
  a_target_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_TARGET |-> !last) else $error("target marked last");
`endif

endmodule
